### hw/rtl/spicds_pkg.sv
// shared types and constants for the spi clock divider search
// used by spicds_div, spicds_datapath, spicds_ctrl and the top level
package spicds_pkg;

  localparam int unsigned SYS_CLOCK_HZ = 80000000;

  localparam int unsigned HZ_W  = 32;
  localparam int unsigned DIV_W = $clog2(SYS_CLOCK_HZ + 1);
  localparam int unsigned PRE_W = 13;
  localparam int unsigned N_W   = 6;
  localparam int unsigned DEN_W = PRE_W + N_W + 1;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  localparam int unsigned SLOWEST_HZ = SYS_CLOCK_HZ / (8192 * 64);

  localparam logic [DIV_W-1:0] SYS_WORD     = DIV_W'(SYS_CLOCK_HZ);
  localparam logic [HZ_W-1:0]  SYS_HZ       = HZ_W'(SYS_CLOCK_HZ);
  localparam logic [HZ_W-1:0]  SLOW_HZ      = HZ_W'(SLOWEST_HZ);
  localparam logic [31:0]      SYSCLK_WORD  = 32'h8000_0000;
  localparam logic [31:0]      SLOWEST_WORD = 32'h7FFF_F000;
  localparam logic [PRE_W-1:0] PRE_MAX      = 13'h1FFF;
  localparam logic [N_W-1:0]   N_MAX        = 6'h3F;
  localparam logic [N_W-1:0]   N_FIRST      = 6'd1;
  localparam logic [1:0]       OFF_LAST     = 2'd3;

  typedef enum logic [1:0] {
    DIV_Q1,
    DIV_BASE,
    DIV_RATE
  } div_sel_t;

  typedef enum logic [1:0] {
    RES_SYSCLK,
    RES_SLOWEST,
    RES_CAND,
    RES_BEST
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     save_q1;
    logic     save_base;
    logic     set_den;
    logic     update;
    logic     next_off;
    logic     next_n;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic sysclk;
    logic slow;
    logic div_done;
    logic exact;
    logic off_last;
    logic n_last;
  } dp_sts_t;

endpackage

### hw/rtl/spicds_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on spicds_pkg
module spicds_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [spicds_pkg::DIV_W-1:0] dividend,
  input  logic [spicds_pkg::DIV_W-1:0] divisor,
  output logic [spicds_pkg::DIV_W-1:0] quotient,
  output logic                        done
);
  import spicds_pkg::*;

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W:0]   rem_diff;

  always_comb begin
    rem_shift = {rem_r, quo_r[DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs_r};
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_shift >= {1'b0, dvs_r}) begin
        rem_nxt = rem_diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### hw/rtl/spicds_datapath.sv
// search datapath: request register, candidate counters, multiplier,
// shared divider, best-candidate tracking and result word; uses spicds_pkg, spicds_div
module spicds_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [spicds_pkg::HZ_W-1:0] req_hz,
  input  spicds_pkg::dp_cmd_t         cmd,
  output spicds_pkg::dp_sts_t         sts,
  output logic [31:0]                 word
);
  import spicds_pkg::*;

  logic [HZ_W-1:0]  freq_r;
  logic [N_W-1:0]   n_r;
  logic [1:0]       off_r;
  logic [DIV_W-1:0] q1_r;
  logic [DIV_W-1:0] q_r;
  logic [PRE_W-1:0] pre_r;
  logic [DEN_W-1:0] den_r;
  logic [DIV_W-1:0] best_rate_r;
  logic [31:0]      best_word_r;
  logic [31:0]      word_r;

  logic [N_W:0]     n_plus1;
  logic [DIV_W:0]   pre_sum;
  logic [DIV_W:0]   pre_off;
  logic [PRE_W-1:0] pre_c;
  logic [DEN_W-1:0] den_c;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic             div_done;
  logic [HZ_W-1:0]  rate_ext;
  logic [31:0]      cand_word;

  spicds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    n_plus1 = {1'b0, n_r} + 1'b1;
    case (cmd.div_sel)
      DIV_Q1: begin
        dvd = SYS_WORD;
        dvs = DIV_W'(n_plus1);
      end
      DIV_BASE: begin
        dvd = q1_r;
        dvs = freq_r[DIV_W-1:0];
      end
      DIV_RATE: begin
        dvd = SYS_WORD;
        dvs = DIV_W'(den_r);
      end
      default: begin
        dvd = SYS_WORD;
        dvs = DIV_W'(n_plus1);
      end
    endcase
  end

  // prescale = quotient - 1 + offset, offset -1..2, clamped to the field
  always_comb begin
    pre_sum = {1'b0, q_r} + (DIV_W + 1)'(off_r);
    pre_off = pre_sum - (DIV_W + 1)'(2);
    if (pre_sum <= (DIV_W + 1)'(2)) begin
      pre_c = '0;
    end else if (pre_off > (DIV_W + 1)'(PRE_MAX)) begin
      pre_c = PRE_MAX;
    end else begin
      pre_c = pre_off[PRE_W-1:0];
    end
    den_c = DEN_W'({1'b0, pre_c} + 1'b1) * DEN_W'(n_plus1);
  end

  assign rate_ext  = HZ_W'(quo);
  assign cand_word = {1'b0, pre_r, n_r, 6'd0, n_plus1[N_W:1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq_r      <= req_hz;
      best_rate_r <= '0;
      best_word_r <= '0;
    end else if (cmd.update) begin
      if (rate_ext < freq_r && quo > best_rate_r) begin
        best_rate_r <= quo;
        best_word_r <= cand_word;
      end
    end
    if (cmd.load) begin
      n_r   <= N_FIRST;
      off_r <= '0;
    end else if (cmd.next_n) begin
      n_r   <= n_r + 1'b1;
      off_r <= '0;
    end else if (cmd.next_off) begin
      off_r <= off_r + 1'b1;
    end
    if (cmd.save_q1) begin
      q1_r <= quo;
    end
    if (cmd.save_base) begin
      q_r <= quo;
    end
    if (cmd.set_den) begin
      pre_r <= pre_c;
      den_r <= den_c;
    end
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RES_SYSCLK:  word_r <= SYSCLK_WORD;
        RES_SLOWEST: word_r <= SLOWEST_WORD;
        RES_CAND:    word_r <= cand_word;
        RES_BEST:    word_r <= best_word_r;
        default:     word_r <= best_word_r;
      endcase
    end
  end

  always_comb begin
    sts.sysclk   = freq_r >= SYS_HZ;
    sts.slow     = (freq_r == '0) || (freq_r < SLOW_HZ);
    sts.div_done = div_done;
    sts.exact    = rate_ext == freq_r;
    sts.off_last = off_r == OFF_LAST;
    sts.n_last   = n_r == N_MAX;
  end

  assign word = word_r;

endmodule

### hw/rtl/spicds_ctrl.sv
// controller state machine for the divider search
// drives spicds_datapath through dp_cmd_t; depends on spicds_pkg
module spicds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  spicds_pkg::dp_sts_t sts,
  output spicds_pkg::dp_cmd_t cmd
);
  import spicds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_Q1_START,
    ST_Q1_WAIT,
    ST_BASE_START,
    ST_BASE_WAIT,
    ST_CAND,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_JUDGE,
    ST_OUT
  } state_t;

  state_t   state_r, state_nxt;
  res_sel_t res_sel_r, res_sel_nxt;
  logic     out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = res_sel_r;
    state_nxt     = state_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (sts.sysclk) begin
          res_sel_nxt = RES_SYSCLK;
          state_nxt   = ST_OUT;
        end else if (sts.slow) begin
          res_sel_nxt = RES_SLOWEST;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt = ST_Q1_START;
        end
      end
      ST_Q1_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Q1;
        state_nxt     = ST_Q1_WAIT;
      end
      ST_Q1_WAIT: begin
        if (sts.div_done) begin
          cmd.save_q1 = 1'b1;
          state_nxt   = ST_BASE_START;
        end
      end
      ST_BASE_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BASE;
        state_nxt     = ST_BASE_WAIT;
      end
      ST_BASE_WAIT: begin
        if (sts.div_done) begin
          cmd.save_base = 1'b1;
          state_nxt     = ST_CAND;
        end
      end
      ST_CAND: begin
        cmd.set_den = 1'b1;
        state_nxt   = ST_RATE_START;
      end
      ST_RATE_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATE;
        state_nxt     = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        if (sts.exact) begin
          res_sel_nxt = RES_CAND;
          state_nxt   = ST_OUT;
        end else begin
          cmd.update = 1'b1;
          if (!sts.off_last) begin
            cmd.next_off = 1'b1;
            state_nxt    = ST_CAND;
          end else if (!sts.n_last) begin
            cmd.next_n = 1'b1;
            state_nxt  = ST_Q1_START;
          end else begin
            res_sel_nxt = RES_BEST;
            state_nxt   = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_sel_r   <= RES_BEST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/spi_clock_divider_search.sv
// top level of the spi clock divider search
// joins spicds_ctrl and spicds_datapath; depends on spicds_pkg
//
// Turns a requested serial clock in hertz into the 32-bit clock register
// word for an 80 MHz system clock. One request gives one result. A request
// at or above the system clock, or below the slowest reachable rate, is
// answered without a search. Otherwise N runs from 1 to 63 and four
// prescale candidates are tried per N; every quotient comes from one shared
// radix-2 divider. An exact match ends the search early. The next request
// is taken once the search ends, while the previous result may still be
// waiting in the output register.
module spi_clock_divider_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // requested_hz
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // clock_word
  output logic [0:0]  out_tuser   // use_system_clock
);
  import spicds_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] word;

  spicds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  spicds_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_hz (in_tdata),
    .cmd    (cmd),
    .sts    (sts),
    .word   (word)
  );

  assign out_tdata    = word;
  assign out_tuser[0] = word == SYSCLK_WORD;

endmodule
